// File: hdl/tcsc_pkg.sv
package tcsc_pkg;

    localparam int KNOB_W      = 10;
    localparam int KNOB_MAX    = 1023;
    localparam int COUNT_W     = 16;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = KNOB_W + CFG_W;
    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 56;
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_PTR_W   = 3;
    localparam int OUT_CNT_W   = 4;

    localparam logic [CFG_W-1:0] FULL_SCALE_RESET = 16'd15000;
    localparam logic [CFG_W-1:0] HOLDOFF_RESET    = 16'd500;
    localparam logic [CFG_W-1:0] SETTLE_RESET     = 16'd500;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 2'd2;

    typedef enum logic
    {
        OP_THRESHOLD = 1'b0,
        OP_CHECK     = 1'b1
    } op_t;

    typedef enum logic
    {
        MODE_TOUCH   = 1'b0,
        MODE_CONTACT = 1'b1
    } mode_t;

    typedef enum logic [2:0]
    {
        RPT_IDLE   = 3'd0,
        RPT_LEFT   = 3'd1,
        RPT_RIGHT  = 3'd2,
        RPT_BOTH   = 3'd3,
        RPT_JOINED = 3'd4
    } report_t;

    // one entry of the knob ring memory
    typedef struct packed
    {
        logic [KNOB_W-1:0] contact;
        logic [KNOB_W-1:0] right;
        logic [KNOB_W-1:0] left;
    } ring_word_t;

    // sensor check fields carried down the pipeline
    typedef struct packed
    {
        logic [TIME_W-1:0]  now_ms;
        logic [KNOB_W-1:0]  contact_level;
        logic [COUNT_W-1:0] touch_right;
        logic [COUNT_W-1:0] touch_left;
    } check_t;

    typedef struct packed
    {
        logic [5:0]         pad;
        logic [KNOB_W-1:0]  contact_threshold;
        logic [COUNT_W-1:0] right_threshold;
        logic [COUNT_W-1:0] left_threshold;
        logic               lamp_joined;
        logic               lamp_right;
        logic               lamp_left;
        logic               relay_level;
        logic               contact_mode;
        logic [2:0]         report_state;
    } result_t;

    // floor(x / 1023) by folding: 1024 is 1 modulo 1023
    function automatic logic [COUNT_W-1:0] div_knob_max(input logic [PROD_W-1:0] x);
        logic [15:0] q0;
        logic [16:0] r0;
        logic [6:0]  q1;
        logic [10:0] r1;
        logic        c;
        q0 = x[25:10];
        r0 = {7'd0, x[9:0]} + {1'b0, q0};
        q1 = r0[16:10];
        r1 = {1'b0, r0[9:0]} + {4'd0, q1};
        c  = (r1 >= 11'(KNOB_MAX));
        return q0 + {9'd0, q1} + {15'd0, c};
    endfunction

endpackage

// File: hdl/touch_contact_sensing_controller_unit.sv
// Touch and contact sensing controller. Each request on the input stream
// (tuser[0] = 0 threshold knob sample, 1 sensor check) yields exactly one
// result, in order. Requests are taken one per clock. The ring memory read
// overlaps the first of four stages (running-sum update, average by
// reciprocal multiply, scaling multiply by full scale, divide by 1023 and
// the sensing state update). An eight-entry result queue decouples the
// output, so input is refused only when eight requests are accepted and not
// yet delivered. The knob rings are cleared at reset through per-entry valid
// bits; there is no clearing pass. Configuration writes are always ready and
// must be issued only while no request is in flight.
module touch_contact_sensing_controller_unit #(
    parameter int AVG_WINDOW = 20
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // knob_left[9:0], knob_right[19:10], knob_contact[29:20], touch_left[45:30],
    // touch_right[61:46], contact_level[71:62], now_ms[103:72]
    input  logic [tcsc_pkg::IN_DATA_W-1:0]          s_axis_tdata,
    // op[0]
    input  logic [0:0]                              s_axis_tuser,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // report_state[2:0], contact_mode[3], relay_level[4], lamp_left[5],
    // lamp_right[6], lamp_joined[7], left_threshold[23:8],
    // right_threshold[39:24], contact_threshold[49:40], zero[55:50]
    output logic [tcsc_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [tcsc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tcsc_pkg::CFG_W-1:0]              cfg_data
);

    localparam int IDX_W  = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int SUM_W  = $clog2(AVG_WINDOW * tcsc_pkg::KNOB_MAX + 1);
    localparam int DIV_L  = $clog2(AVG_WINDOW);
    localparam int DIV_S  = SUM_W + DIV_L;
    localparam longint DIV_M = ((64'd1 << DIV_S) + AVG_WINDOW - 1) / AVG_WINDOW;
    localparam int M_W    = $clog2(DIV_M + 1);
    localparam int P_W    = SUM_W + M_W;
    localparam int KW     = tcsc_pkg::KNOB_W;
    localparam int RW     = 3 * tcsc_pkg::KNOB_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AVG_WINDOW - 1);

    // configuration
    logic [tcsc_pkg::CFG_W-1:0] full_scale_reg;
    logic [tcsc_pkg::CFG_W-1:0] holdoff_reg;
    logic [tcsc_pkg::CFG_W-1:0] settle_reg;

    // input side
    logic                 s_accept;
    logic                 m_pop;
    tcsc_pkg::op_t        in_op;
    tcsc_pkg::ring_word_t in_knobs;
    tcsc_pkg::check_t     in_chk;
    logic [IDX_W-1:0]     ring_index_reg;

    // ring memory and forwarding
    logic                 ram_wr_en;
    tcsc_pkg::ring_word_t ram_wr_data;
    logic [RW-1:0]        ram_rd_data;
    logic [AVG_WINDOW-1:0] entry_valid_reg;
    logic                 fwd_hit_reg;
    tcsc_pkg::ring_word_t fwd_data_reg;
    tcsc_pkg::ring_word_t old_word;

    // stage 1: running sums
    logic                 s1_valid_reg;
    tcsc_pkg::op_t        s1_op_reg;
    tcsc_pkg::ring_word_t s1_knobs_reg;
    tcsc_pkg::check_t     s1_chk_reg;
    logic [IDX_W-1:0]     s1_addr_reg;
    logic [SUM_W-1:0]     sum_l_reg;
    logic [SUM_W-1:0]     sum_r_reg;
    logic [SUM_W-1:0]     sum_c_reg;
    logic [SUM_W-1:0]     sum_l_next;
    logic [SUM_W-1:0]     sum_r_next;
    logic [SUM_W-1:0]     sum_c_next;

    // stage 2: averages
    logic                 s2_valid_reg;
    tcsc_pkg::op_t        s2_op_reg;
    tcsc_pkg::check_t     s2_chk_reg;
    logic [SUM_W-1:0]     s2_sum_l_reg;
    logic [SUM_W-1:0]     s2_sum_r_reg;
    logic [SUM_W-1:0]     s2_sum_c_reg;
    logic [P_W-1:0]       recip_l;
    logic [P_W-1:0]       recip_r;
    logic [P_W-1:0]       recip_c;

    // stage 3: scaling
    logic                 s3_valid_reg;
    tcsc_pkg::op_t        s3_op_reg;
    tcsc_pkg::check_t     s3_chk_reg;
    logic [KW-1:0]        s3_avg_l_reg;
    logic [KW-1:0]        s3_avg_r_reg;
    logic [KW-1:0]        s3_avg_c_reg;

    // stage 4: divide and sensing state
    logic                 s4_valid_reg;
    tcsc_pkg::op_t        s4_op_reg;
    tcsc_pkg::check_t     s4_chk_reg;
    logic [tcsc_pkg::PROD_W-1:0] s4_prod_l_reg;
    logic [tcsc_pkg::PROD_W-1:0] s4_prod_r_reg;
    logic [KW-1:0]        s4_avg_c_reg;

    tcsc_pkg::mode_t      mode_reg;
    tcsc_pkg::mode_t      mode_next;
    tcsc_pkg::report_t    report_reg;
    tcsc_pkg::report_t    report_next;
    logic [tcsc_pkg::TIME_W-1:0]  touch_time_reg;
    logic [tcsc_pkg::TIME_W-1:0]  touch_time_next;
    logic [tcsc_pkg::TIME_W-1:0]  contact_time_reg;
    logic [tcsc_pkg::TIME_W-1:0]  contact_time_next;
    logic [tcsc_pkg::COUNT_W-1:0] thr_l_reg;
    logic [tcsc_pkg::COUNT_W-1:0] thr_l_next;
    logic [tcsc_pkg::COUNT_W-1:0] thr_r_reg;
    logic [tcsc_pkg::COUNT_W-1:0] thr_r_next;
    logic [KW-1:0]        thr_c_reg;
    logic [KW-1:0]        thr_c_next;
    logic                 left_active;
    logic                 right_active;
    logic                 holdoff_done;
    logic                 settling;
    tcsc_pkg::result_t    result;

    // result queue
    tcsc_pkg::result_t    queue_reg [tcsc_pkg::OUT_DEPTH];
    logic [tcsc_pkg::OUT_PTR_W-1:0] wr_ptr_reg;
    logic [tcsc_pkg::OUT_PTR_W-1:0] rd_ptr_reg;
    logic [tcsc_pkg::OUT_CNT_W-1:0] queue_cnt_reg;
    logic [tcsc_pkg::OUT_CNT_W-1:0] pending_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (pending_reg < tcsc_pkg::OUT_CNT_W'(tcsc_pkg::OUT_DEPTH));
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (queue_cnt_reg != '0);
    assign m_pop         = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = queue_reg[rd_ptr_reg];

    assign in_op                  = tcsc_pkg::op_t'(s_axis_tuser[0]);
    assign in_knobs.left          = s_axis_tdata[9:0];
    assign in_knobs.right         = s_axis_tdata[19:10];
    assign in_knobs.contact       = s_axis_tdata[29:20];
    assign in_chk.touch_left      = s_axis_tdata[45:30];
    assign in_chk.touch_right     = s_axis_tdata[61:46];
    assign in_chk.contact_level   = s_axis_tdata[71:62];
    assign in_chk.now_ms          = s_axis_tdata[103:72];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= tcsc_pkg::FULL_SCALE_RESET;
            holdoff_reg    <= tcsc_pkg::HOLDOFF_RESET;
            settle_reg     <= tcsc_pkg::SETTLE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tcsc_pkg::CFG_FULL_SCALE: full_scale_reg <= cfg_data;
                tcsc_pkg::CFG_HOLDOFF:    holdoff_reg    <= cfg_data;
                tcsc_pkg::CFG_SETTLE:     settle_reg     <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // ring memory: read at accept, write back from stage 1
    assign ram_wr_en   = s1_valid_reg && (s1_op_reg == tcsc_pkg::OP_THRESHOLD);
    assign ram_wr_data = s1_knobs_reg;

    tcsc_ram #(
        .WIDTH (RW),
        .DEPTH (AVG_WINDOW)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (s_accept),
        .rd_addr (ring_index_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            old_word = fwd_data_reg;
        end
        else if (entry_valid_reg[s1_addr_reg])
        begin
            old_word = tcsc_pkg::ring_word_t'(ram_rd_data);
        end
        else
        begin
            old_word = '0;
        end
    end

    assign sum_l_next = sum_l_reg - SUM_W'(old_word.left) + SUM_W'(s1_knobs_reg.left);
    assign sum_r_next = sum_r_reg - SUM_W'(old_word.right) + SUM_W'(s1_knobs_reg.right);
    assign sum_c_next = sum_c_reg - SUM_W'(old_word.contact) + SUM_W'(s1_knobs_reg.contact);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_index_reg  <= '0;
            entry_valid_reg <= '0;
            fwd_hit_reg     <= 1'b0;
            sum_l_reg       <= '0;
            sum_r_reg       <= '0;
            sum_c_reg       <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s_accept && (in_op == tcsc_pkg::OP_THRESHOLD))
            begin
                ring_index_reg <= (ring_index_reg == LAST_IDX) ? '0 : ring_index_reg + 1'b1;
            end
            // catch a write-back that lands on the entry being read
            fwd_hit_reg <= ram_wr_en && (s1_addr_reg == ring_index_reg);
            if (ram_wr_en)
            begin
                entry_valid_reg[s1_addr_reg] <= 1'b1;
                sum_l_reg <= sum_l_next;
                sum_r_reg <= sum_r_next;
                sum_c_reg <= sum_c_next;
            end
            s1_valid_reg <= s_accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    assign recip_l = P_W'(s2_sum_l_reg) * P_W'(DIV_M);
    assign recip_r = P_W'(s2_sum_r_reg) * P_W'(DIV_M);
    assign recip_c = P_W'(s2_sum_c_reg) * P_W'(DIV_M);

    always_ff @(posedge clk)
    begin
        fwd_data_reg  <= ram_wr_data;
        s1_op_reg     <= in_op;
        s1_knobs_reg  <= in_knobs;
        s1_chk_reg    <= in_chk;
        s1_addr_reg   <= ring_index_reg;

        s2_op_reg     <= s1_op_reg;
        s2_chk_reg    <= s1_chk_reg;
        s2_sum_l_reg  <= sum_l_next;
        s2_sum_r_reg  <= sum_r_next;
        s2_sum_c_reg  <= sum_c_next;

        s3_op_reg     <= s2_op_reg;
        s3_chk_reg    <= s2_chk_reg;
        s3_avg_l_reg  <= recip_l[DIV_S +: KW];
        s3_avg_r_reg  <= recip_r[DIV_S +: KW];
        s3_avg_c_reg  <= recip_c[DIV_S +: KW];

        s4_op_reg     <= s3_op_reg;
        s4_chk_reg    <= s3_chk_reg;
        s4_prod_l_reg <= tcsc_pkg::PROD_W'(s3_avg_l_reg) * tcsc_pkg::PROD_W'(full_scale_reg);
        s4_prod_r_reg <= tcsc_pkg::PROD_W'(s3_avg_r_reg) * tcsc_pkg::PROD_W'(full_scale_reg);
        s4_avg_c_reg  <= s3_avg_c_reg;
    end

    // sensing state
    assign left_active  = (s4_chk_reg.touch_left > thr_l_reg);
    assign right_active = (s4_chk_reg.touch_right > thr_r_reg);
    assign holdoff_done = ((s4_chk_reg.now_ms - touch_time_reg) >
                           tcsc_pkg::TIME_W'(holdoff_reg));
    assign settling     = ((s4_chk_reg.now_ms - contact_time_reg) <
                           tcsc_pkg::TIME_W'(settle_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= tcsc_pkg::MODE_TOUCH;
            report_reg       <= tcsc_pkg::RPT_IDLE;
            touch_time_reg   <= '0;
            contact_time_reg <= '0;
            thr_l_reg        <= tcsc_pkg::FULL_SCALE_RESET;
            thr_r_reg        <= tcsc_pkg::FULL_SCALE_RESET;
            thr_c_reg        <= '0;
        end
        else
        begin
            mode_reg         <= mode_next;
            report_reg       <= report_next;
            touch_time_reg   <= touch_time_next;
            contact_time_reg <= contact_time_next;
            thr_l_reg        <= thr_l_next;
            thr_r_reg        <= thr_r_next;
            thr_c_reg        <= thr_c_next;
        end
    end

    always_comb
    begin
        mode_next         = mode_reg;
        report_next       = report_reg;
        touch_time_next   = touch_time_reg;
        contact_time_next = contact_time_reg;
        thr_l_next        = thr_l_reg;
        thr_r_next        = thr_r_reg;
        thr_c_next        = thr_c_reg;
        if (s4_valid_reg)
        begin
            if (s4_op_reg == tcsc_pkg::OP_THRESHOLD)
            begin
                thr_l_next = tcsc_pkg::div_knob_max(s4_prod_l_reg);
                thr_r_next = tcsc_pkg::div_knob_max(s4_prod_r_reg);
                thr_c_next = s4_avg_c_reg;
            end
            else
            begin
                unique case (mode_reg)
                    tcsc_pkg::MODE_TOUCH:
                    begin
                        if (left_active && right_active)
                        begin
                            report_next = tcsc_pkg::RPT_BOTH;
                            if (holdoff_done)
                            begin
                                mode_next         = tcsc_pkg::MODE_CONTACT;
                                contact_time_next = s4_chk_reg.now_ms;
                            end
                        end
                        else if (left_active)
                        begin
                            report_next = tcsc_pkg::RPT_LEFT;
                        end
                        else if (right_active)
                        begin
                            report_next = tcsc_pkg::RPT_RIGHT;
                        end
                        else
                        begin
                            report_next = tcsc_pkg::RPT_IDLE;
                        end
                    end
                    tcsc_pkg::MODE_CONTACT:
                    begin
                        if (s4_chk_reg.contact_level < thr_c_reg)
                        begin
                            report_next       = tcsc_pkg::RPT_JOINED;
                            contact_time_next = s4_chk_reg.now_ms;
                        end
                        else if ((report_reg == tcsc_pkg::RPT_JOINED) || !settling)
                        begin
                            // give up and go back to touch sensing, report held
                            mode_next       = tcsc_pkg::MODE_TOUCH;
                            touch_time_next = s4_chk_reg.now_ms;
                        end
                    end
                    default:
                    begin
                        mode_next = tcsc_pkg::MODE_TOUCH;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result                   = '0;
        result.report_state      = report_next;
        result.contact_mode      = (mode_next == tcsc_pkg::MODE_CONTACT);
        result.relay_level       = (mode_next == tcsc_pkg::MODE_TOUCH);
        result.lamp_left         = (report_next == tcsc_pkg::RPT_LEFT) ||
                                   (report_next == tcsc_pkg::RPT_BOTH);
        result.lamp_right        = (report_next == tcsc_pkg::RPT_RIGHT) ||
                                   (report_next == tcsc_pkg::RPT_BOTH);
        result.lamp_joined       = (report_next == tcsc_pkg::RPT_JOINED);
        result.left_threshold    = thr_l_next;
        result.right_threshold   = thr_r_next;
        result.contact_threshold = thr_c_next;
    end

    // result queue; pending counts every request not yet delivered,
    // so the queue cannot overflow
    always_ff @(posedge clk)
    begin
        if (s4_valid_reg)
        begin
            queue_reg[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            queue_cnt_reg <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            if (s4_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (m_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({s4_valid_reg, m_pop})
                2'b10:   queue_cnt_reg <= queue_cnt_reg + 1'b1;
                2'b01:   queue_cnt_reg <= queue_cnt_reg - 1'b1;
                default: ;
            endcase
            case ({s_accept, m_pop})
                2'b10:   pending_reg <= pending_reg + 1'b1;
                2'b01:   pending_reg <= pending_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/tcsc_ram.sv
module tcsc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 20
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word when the same entry is written in that cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcsc_pkg::*;

    localparam int AVG_WIN         = 20;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 204;
    localparam int DRAIN_CYCLES    = 12;
    localparam int LONG_HOLD       = 300;
    localparam longint LIMIT_NS    = 5_000_000;

    // index past the last register; the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    class sense_tracker;
        int unsigned       full_scale;
        int unsigned       holdoff_ms;
        int unsigned       settle_ms;
        logic [KNOB_W-1:0] left_ring [AVG_WIN];
        logic [KNOB_W-1:0] right_ring [AVG_WIN];
        logic [KNOB_W-1:0] contact_ring [AVG_WIN];
        int unsigned       slot;
        int unsigned       left_sum;
        int unsigned       right_sum;
        int unsigned       contact_sum;
        logic [COUNT_W-1:0] left_thr;
        logic [COUNT_W-1:0] right_thr;
        logic [KNOB_W-1:0]  contact_thr;
        mode_t             mode;
        report_t           report;
        logic [TIME_W-1:0] touch_since;
        logic [TIME_W-1:0] contact_since;
        result_t           pending_reports [$];
        int                errors;
        int                matched;
        int                contact_entries;
        int                joined_seen;

        function new();
            full_scale = FULL_SCALE_RESET;
            holdoff_ms = HOLDOFF_RESET;
            settle_ms = SETTLE_RESET;
            foreach (left_ring[i])
            begin
                left_ring[i] = '0;
                right_ring[i] = '0;
                contact_ring[i] = '0;
            end
            slot = 0;
            left_sum = 0;
            right_sum = 0;
            contact_sum = 0;
            left_thr = FULL_SCALE_RESET;
            right_thr = FULL_SCALE_RESET;
            contact_thr = '0;
            mode = MODE_TOUCH;
            report = RPT_IDLE;
            touch_since = '0;
            contact_since = '0;
            errors = 0;
            matched = 0;
            contact_entries = 0;
            joined_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
            case (index)
                CFG_FULL_SCALE: full_scale = value;
                CFG_HOLDOFF:    holdoff_ms = value;
                CFG_SETTLE:     settle_ms = value;
                default:        ;
            endcase
        endfunction

        function logic [COUNT_W-1:0] scaled(int unsigned sum);
            int unsigned prod;
            prod = (sum / AVG_WIN) * full_scale;
            return COUNT_W'(prod / KNOB_MAX);
        endfunction

        function void take_request(op_t op, ring_word_t knobs, check_t chk);
            result_t     r;
            logic        left_on;
            logic        right_on;
            int unsigned elapsed;
            if (op == OP_THRESHOLD)
            begin
                left_sum = left_sum - left_ring[slot] + knobs.left;
                right_sum = right_sum - right_ring[slot] + knobs.right;
                contact_sum = contact_sum - contact_ring[slot] + knobs.contact;
                left_ring[slot] = knobs.left;
                right_ring[slot] = knobs.right;
                contact_ring[slot] = knobs.contact;
                left_thr = scaled(left_sum);
                right_thr = scaled(right_sum);
                contact_thr = KNOB_W'(contact_sum / AVG_WIN);
                slot = (slot == AVG_WIN - 1) ? 0 : slot + 1;
            end
            else if (mode == MODE_TOUCH)
            begin
                left_on = chk.touch_left > left_thr;
                right_on = chk.touch_right > right_thr;
                if (left_on && right_on)
                begin
                    report = RPT_BOTH;
                    elapsed = chk.now_ms - touch_since;
                    if (elapsed > holdoff_ms)
                    begin
                        mode = MODE_CONTACT;
                        contact_since = chk.now_ms;
                        contact_entries++;
                    end
                end
                else if (left_on)
                    report = RPT_LEFT;
                else if (right_on)
                    report = RPT_RIGHT;
                else
                    report = RPT_IDLE;
            end
            else
            begin
                elapsed = chk.now_ms - contact_since;
                if (chk.contact_level < contact_thr)
                begin
                    report = RPT_JOINED;
                    contact_since = chk.now_ms;
                end
                else if (report != RPT_JOINED && elapsed < settle_ms)
                begin
                    // hold contact mode until the settle window runs out
                end
                else
                begin
                    mode = MODE_TOUCH;
                    touch_since = chk.now_ms;
                end
            end
            r = '0;
            r.report_state = report;
            r.contact_mode = (mode == MODE_CONTACT);
            r.relay_level = (mode == MODE_TOUCH);
            r.lamp_left = (report == RPT_LEFT || report == RPT_BOTH);
            r.lamp_right = (report == RPT_RIGHT || report == RPT_BOTH);
            r.lamp_joined = (report == RPT_JOINED);
            r.left_threshold = left_thr;
            r.right_threshold = right_thr;
            r.contact_threshold = contact_thr;
            pending_reports.push_back(r);
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_report(logic [OUT_DATA_W-1:0] data);
            result_t got;
            result_t want;
            got = data;
            if (pending_reports.size() == 0)
            begin
                $display("%0t: result expected none, actual %h", $time, data);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            matched++;
            if (want.report_state == RPT_JOINED)
                joined_seen++;
            check_field("report_state", want.report_state, got.report_state);
            check_field("contact_mode", want.contact_mode, got.contact_mode);
            check_field("relay_level", want.relay_level, got.relay_level);
            check_field("lamp_left", want.lamp_left, got.lamp_left);
            check_field("lamp_right", want.lamp_right, got.lamp_right);
            check_field("lamp_joined", want.lamp_joined, got.lamp_joined);
            check_field("left_threshold", want.left_threshold, got.left_threshold);
            check_field("right_threshold", want.right_threshold, got.right_threshold);
            check_field("contact_threshold", want.contact_threshold,
                        got.contact_threshold);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    sense_tracker      tracker = new();
    int                src_idle_pct = 0;
    int                sink_stall_pct = 0;
    int                hold_req = 0;
    int                hold_left = 0;
    int                sent = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    touch_contact_sensing_controller_unit #(
        .AVG_WINDOW(AVG_WIN)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: random stalls, plus one long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_report(m_axis_tdata);
    end

    task automatic push_request(op_t op, ring_word_t knobs, check_t chk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {chk, knobs};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.take_request(op, knobs, chk);
        sent++;
    endtask

    task automatic send_check(logic [COUNT_W-1:0] tl, logic [COUNT_W-1:0] tr,
                              logic [KNOB_W-1:0] level, logic [TIME_W-1:0] now);
        check_t     chk;
        ring_word_t knobs;
        chk.touch_left = tl;
        chk.touch_right = tr;
        chk.contact_level = level;
        chk.now_ms = now;
        // knob fields are don't-care on a check; scramble them
        knobs = {KNOB_W'($urandom), KNOB_W'($urandom), KNOB_W'($urandom)};
        push_request(OP_CHECK, knobs, chk);
    endtask

    task automatic send_knobs(logic [KNOB_W-1:0] kl, logic [KNOB_W-1:0] kr,
                              logic [KNOB_W-1:0] kc);
        check_t     chk;
        ring_word_t knobs;
        knobs.left = kl;
        knobs.right = kr;
        knobs.contact = kc;
        chk = {TIME_W'($urandom), KNOB_W'($urandom), COUNT_W'($urandom),
               COUNT_W'($urandom)};
        push_request(OP_THRESHOLD, knobs, chk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // count that lands above the threshold most of the time
    function automatic logic [COUNT_W-1:0] touch_near(logic [COUNT_W-1:0] thr);
        if (thr != '1 && $urandom_range(0, 99) < 70)
            return COUNT_W'($urandom_range(65535, int'(thr) + 1));
        return COUNT_W'($urandom_range(int'(thr), 0));
    endfunction

    task automatic random_request();
        int                pick;
        int unsigned       step;
        logic [KNOB_W-1:0] level;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            if ($urandom_range(0, 1) == 1)
                send_knobs(KNOB_W'($urandom), KNOB_W'($urandom), KNOB_W'($urandom));
            else
                send_knobs(KNOB_W'($urandom_range(0, 300)), KNOB_W'($urandom_range(0, 300)),
                           KNOB_W'($urandom_range(200, 1023)));
        end
        else if (pick < 92)
        begin
            step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70000)
                                               : $urandom_range(0, 400);
            clock_ms = clock_ms + step;
            if (tracker.contact_thr != '0 && $urandom_range(0, 99) < 60)
                level = KNOB_W'($urandom_range(int'(tracker.contact_thr) - 1, 0));
            else
                level = KNOB_W'($urandom_range(1023, int'(tracker.contact_thr)));
            send_check(touch_near(tracker.left_thr), touch_near(tracker.right_thr),
                       level, clock_ms);
        end
        else if ($urandom_range(0, 1) == 1)
            send_check(COUNT_W'($urandom), COUNT_W'($urandom), KNOB_W'($urandom), $urandom);
        else
            send_knobs(KNOB_W'($urandom), KNOB_W'($urandom), KNOB_W'($urandom));
    endtask

    initial
    begin
        logic [CFG_W-1:0] scale_set [NUM_PHASES];
        logic [CFG_W-1:0] holdoff_set [NUM_PHASES];
        logic [CFG_W-1:0] settle_set [NUM_PHASES];
        scale_set = '{16'd15000, 16'd65535, 16'd0, CFG_W'($urandom), 16'd1023,
                      16'd15000, CFG_W'($urandom), 16'd40000};
        holdoff_set = '{16'd500, 16'd0, 16'd65535, CFG_W'($urandom), 16'd100,
                        16'd500, CFG_W'($urandom), 16'd20};
        settle_set = '{16'd500, 16'd0, 16'd65535, CFG_W'($urandom), 16'd300,
                       16'd500, CFG_W'($urandom), 16'd1000};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_reg(CFG_FULL_SCALE, scale_set[ph]);
            write_reg(CFG_HOLDOFF, holdoff_set[ph]);
            write_reg(CFG_SETTLE, settle_set[ph]);
            if (ph == 0)
                write_reg(CFG_UNUSED, CFG_W'($urandom));
            case (ph % 4)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 80;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 80;
                end
                default:
                begin
                    src_idle_pct = 12;
                    sink_stall_pct = 12;
                end
            endcase
            // back up the result queue so the input has to stall
            if (ph == 4)
                hold_req = LONG_HOLD;
            if (ph == 5)
                clock_ms = 32'hFFFF_0000;

            if (ph == 0)
            begin
                // reset thresholds, zero contact threshold, default timing
                send_check(16'd0, 16'd0, 10'd0, 32'd0);
                send_check(16'hFFFF, 16'd0, 10'h3FF, 32'd1);
                send_check(16'd0, 16'hFFFF, 10'd0, 32'd2);
                send_check(16'd15000, 16'd15000, 10'd0, 32'd3);
                send_check(16'hFFFF, 16'hFFFF, 10'd0, 32'd500);
                send_check(16'hFFFF, 16'hFFFF, 10'd0, 32'd501);
                send_check(16'd0, 16'd0, 10'd0, 32'd600);
                send_check(16'd0, 16'd0, 10'h3FF, 32'd1001);
                send_check(16'd0, 16'd0, 10'd0, 32'd1002);
                repeat (6) send_knobs(10'h3FF, 10'h3FF, 10'h3FF);
                send_knobs(10'd0, 10'd0, 10'd0);
                // contact entry just before the time wraps
                send_check(16'hFFFF, 16'hFFFF, 10'd0, 32'hFFFF_FF00);
                send_check(16'd0, 16'd0, 10'd305, 32'hFFFF_FF80);
                send_check(16'd0, 16'd0, 10'h3FF, 32'hFFFF_FF81);
                send_check(16'hFFFF, 16'hFFFF, 10'h3FF, 32'h0000_0100);
                send_check(16'hFFFF, 16'hFFFF, 10'h3FF, 32'h0000_0200);
                send_check(16'd0, 16'd0, 10'd306, 32'h0000_03F3);
                send_check(16'd0, 16'd0, 10'd306, 32'h0000_03F4);
                clock_ms = 32'h0000_0400;
            end

            repeat (ITEMS_PER_PHASE) random_request();
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            while (tracker.pending_reports.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end

        $display("tb: %0d requests over %0d register settings, %0d results compared",
                 sent, NUM_PHASES, tracker.matched);
        $display("tb: contact mode entered %0d times, joined reported %0d times",
                 tracker.contact_entries, tracker.joined_seen);
        if (tracker.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("%0t: timeout, %0d results outstanding", $time,
                 tracker.pending_reports.size());
        $display("tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
hdl/tcsc_pkg.sv
hdl/tcsc_ram.sv
hdl/touch_contact_sensing_controller_unit.sv
verif/tb.sv
